@@ src/erspf_pkg.sv @@
// shared constants, widths and table builders for the ewald real-space pair force engine
package erspf_pkg;

   // table grid
   localparam int TABLE_ENTRIES = 1024;
   localparam int U_LIMIT       = 8;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int ROM_AW        = $clog2(TABLE_ENTRIES + 1);
   localparam int EXP_TERMS     = 20;

   // fixed-point constants, unsigned q.32
   localparam logic [63:0] ONE_Q32           = 64'h1_0000_0000;
   localparam logic [63:0] INV_E_Q32         = 64'd1580030169;
   localparam logic [32:0] TWO_INV_SQRTPI    = 33'd4846351620;
   localparam logic [63:0] SIMPSON_K_Q32     = 64'd6461802160;

   // output clamps
   localparam logic [47:0] OUT_POS_CAP = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] OUT_NEG_CAP = 48'h8000_0000_0000;

   // wide multiplier
   localparam int MUL_W   = 96;
   localparam int MUL_LAT = 3;

   // long divider
   localparam int DIV_NUM_W  = 113;
   localparam int DIV_DEN_W  = 64;
   localparam int DIV_QUO_W  = 84;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = DIV_QUO_W / DIV_STEPS;

   typedef logic [32:0] rom_type [0:TABLE_ENTRIES];

   // exp(-v), v and result q.32
   function automatic logic [63:0] exp_neg_q32(input logic [63:0] v);
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] sum;
      logic [63:0] term;
      n    = v >> 32;
      f    = {32'b0, v[31:0]};
      sum  = ONE_Q32;
      term = ONE_Q32;
      if (n >= 64'd23) begin
         return 64'd0;
      end
      for (int k = 1; k <= EXP_TERMS; k++) begin
         term = ((term * f) >> 32) / 64'(k);
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int k = 0; k < 23; k++) begin
         if (64'(k) < n) begin
            sum = (sum * INV_E_Q32) >> 32;
         end
      end
      return sum;
   endfunction

   // exp(-u^2) at half-grid point j
   function automatic logic [63:0] grid_exp(input logic [63:0] j);
      logic [63:0] u24;
      u24 = (j * (64'(U_LIMIT) << 23)) / TABLE_ENTRIES;
      return exp_neg_q32((u24 * u24) >> 16);
   endfunction

   function automatic rom_type build_exp_rom();
      rom_type rom;
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         rom[i] = 33'(grid_exp(64'(2 * i)));
      end
      return rom;
   endfunction

   // simpson sum from the top of the grid down
   function automatic rom_type build_erfc_rom();
      rom_type      rom;
      logic [63:0]  s;
      logic [127:0] prod;
      logic [63:0]  v;
      s = 64'd0;
      rom[TABLE_ENTRIES] = 33'd0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         s = s + grid_exp(64'(2 * i)) + 64'd4 * grid_exp(64'(2 * i + 1))
             + grid_exp(64'(2 * i + 2));
         prod = {64'b0, s} * {64'b0, SIMPSON_K_Q32};
         v = prod[95:32] / TABLE_ENTRIES;
         rom[i] = (v > ONE_Q32) ? 33'(ONE_Q32) : 33'(v);
      end
      return rom;
   endfunction

endpackage

@@ src/ewald_real_space_pair_force.sv @@
// top level: ewald real-space coulomb pair force pipeline with apb register port
// One atom pair is taken per clock cycle and one result leaves per cycle
// while no result is held by rsp_stall. The pipeline holds the 32-step square
// root (8 stages), the 84-bit long dividers of the two division steps (21
// stages each) and the 3-stage wide multipliers in front of and behind the
// second divider. A stalled result holds the whole pipeline. The exp and erfc
// tables are constant and are ready right after reset; there is no fill pass.
// Registers alpha (address 0) and k_coulomb (address 4) are to be written only
// while no request is in flight.
module ewald_real_space_pair_force import erspf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_dx,
   input  logic signed [31:0] req_dy,
   input  logic signed [31:0] req_dz,
   input  logic signed [15:0] req_charge_first,
   input  logic signed [15:0] req_charge_second,
   input  logic [17:0]        req_pair_scale,
   input  logic [31:0]        req_mass_inv_first,
   input  logic [31:0]        req_mass_inv_second,
   input  logic               req_count_virial,
   input  logic               req_partner_ghost,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_acc_first_x,
   output logic signed [47:0] rsp_acc_first_y,
   output logic signed [47:0] rsp_acc_first_z,
   output logic signed [47:0] rsp_acc_second_x,
   output logic signed [47:0] rsp_acc_second_y,
   output logic signed [47:0] rsp_acc_second_z,
   output logic signed [47:0] rsp_virial_term,
   output logic               rsp_skipped,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // register indexes
   localparam logic REG_ALPHA = 1'b0;
   localparam logic REG_KCOUL = 1'b1;

   // stage map
   localparam int ST_MAG       = 1;
   localparam int ST_R2        = 2;
   localparam int ST_ROOT      = 3;
   localparam int SQRT_STAGES  = 8;
   localparam int SQRT_PER     = 32 / SQRT_STAGES;
   localparam int ST_ROOT_END  = ST_ROOT + SQRT_STAGES - 1;
   localparam int ST_U         = ST_ROOT_END + 1;
   localparam int ST_P         = ST_U + 1;
   localparam int ST_ROM       = ST_P + 1;
   localparam int ST_LERP      = ST_ROM + 1;
   localparam int ST_EC        = ST_LERP + 1;
   localparam int ST_TE        = ST_EC + 1;
   localparam int ST_T1        = ST_TE + 1;
   localparam int ST_SKQ       = ST_MAG + MUL_LAT;
   localparam int ST_PM        = ST_SKQ + MUL_LAT;
   localparam int ST_T2        = ST_EC + DIV_STAGES;
   localparam int ST_B         = ST_T2 + 1;
   localparam int ST_BD        = ST_B + MUL_LAT;
   localparam int ST_H         = ST_BD + DIV_STAGES;
   localparam int LAST         = ST_H + MUL_LAT;

   localparam rom_type EXP_ROM  = build_exp_rom();
   localparam rom_type ERFC_ROM = build_erfc_rom();

   typedef struct packed {
      logic [31:0]       dx;
      logic [31:0]       dy;
      logic [31:0]       dz;
      logic [15:0]       qi;
      logic [15:0]       qj;
      logic [17:0]       scale;
      logic [31:0]       mi;
      logic [31:0]       mj;
      logic              count;
      logic              ghost;
      logic [2:0][31:0]  dmag;
      logic [2:0]        dneg;
      logic              qneg_i;
      logic              qneg_j;
      logic [2:0][63:0]  sq;
      logic [30:0]       q;
      logic [49:0]       sk;
      logic              skip;
      logic [63:0]       r2;
      logic [63:0]       sx;
      logic [63:0]       sres;
      logic [55:0]       u;
      logic [IDX_W-1:0]  idx;
      logic [31:0]       frac;
      logic              inrange;
      logic [32:0]       ea;
      logic [32:0]       eb;
      logic [32:0]       ca;
      logic [32:0]       cb;
      logic [64:0]       e_prod;
      logic              e_dn;
      logic [64:0]       c_prod;
      logic              c_dn;
      logic [32:0]       e;
      logic [32:0]       c;
      logic [65:0]       te;
      logic [41:0]       t1;
      logic [79:0]       skq;
      logic [79:0]       pm_i;
      logic [79:0]       pm_j;
      logic [49:0]       b;
      logic [47:0]       vmag;
   } pipe_type;

   typedef struct packed {
      logic [2:0][47:0] acc_i;
      logic [2:0][47:0] acc_j;
      logic [47:0]      vir;
      logic             skipped;
   } rsp_type;

   logic [23:0]  alpha_ff;
   logic [31:0]  k_coulomb_ff;
   logic         advance;
   pipe_type     pipe_ff [0:LAST];
   pipe_type     pipe_in [0:LAST];
   logic [LAST:0] vld_ff;
   rsp_type      rsp_ff;
   rsp_type      rsp_in;
   logic         rsp_valid_ff;

   logic [2*MUL_W-1:0]   skq_prod;
   logic [2*MUL_W-1:0]   pmi_prod;
   logic [2*MUL_W-1:0]   pmj_prod;
   logic [2*MUL_W-1:0]   vir_prod;
   logic [2*MUL_W-1:0]   bd_prod   [3];
   logic [2*MUL_W-1:0]   acci_prod [3];
   logic [2*MUL_W-1:0]   accj_prod [3];
   logic [DIV_QUO_W-1:0] t2_quo;
   logic [DIV_QUO_W-1:0] h_quo     [3];

   function automatic logic [47:0] sat_out(input logic [127:0] m, input logic neg);
      logic [47:0] v;
      if (neg) begin
         v = (m > 128'(OUT_NEG_CAP)) ? OUT_NEG_CAP : m[47:0];
         v = 48'd0 - v;
      end else begin
         v = (m > 128'(OUT_POS_CAP)) ? OUT_POS_CAP : m[47:0];
      end
      return v;
   endfunction

   // handshake: the whole pipeline moves unless a result is held
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_KCOUL) ? k_coulomb_ff : {8'b0, alpha_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= 24'd65536;
         k_coulomb_ff <= 32'd65536;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_ALPHA: alpha_ff     <= pwdata[23:0];
            REG_KCOUL: k_coulomb_ff <= pwdata;
            default:   alpha_ff     <= alpha_ff;
         endcase
      end
   end

   // stage logic
   always_comb begin
      logic [63:0] sx;
      logic [63:0] sres;
      logic [63:0] bitv;
      logic [71:0] pw;
      logic [ROM_AW-1:0] addr_a;
      logic [ROM_AW-1:0] addr_b;
      logic [32:0] diff;
      logic [15:0] qm_i;
      logic [15:0] qm_j;

      pipe_in[0] = '0;
      for (int s = 1; s <= LAST; s++) begin
         pipe_in[s] = pipe_ff[s-1];
      end

      // request capture
      pipe_in[0].dx    = req_dx;
      pipe_in[0].dy    = req_dy;
      pipe_in[0].dz    = req_dz;
      pipe_in[0].qi    = req_charge_first;
      pipe_in[0].qj    = req_charge_second;
      pipe_in[0].scale = req_pair_scale;
      pipe_in[0].mi    = req_mass_inv_first;
      pipe_in[0].mj    = req_mass_inv_second;
      pipe_in[0].count = req_count_virial;
      pipe_in[0].ghost = req_partner_ghost;

      // magnitudes, squares, charge product, scale times k
      pipe_in[ST_MAG].dneg = {pipe_ff[ST_MAG-1].dz[31], pipe_ff[ST_MAG-1].dy[31],
                              pipe_ff[ST_MAG-1].dx[31]};
      pipe_in[ST_MAG].dmag[0] = pipe_ff[ST_MAG-1].dx[31] ? (~pipe_ff[ST_MAG-1].dx + 32'd1)
                                                         : pipe_ff[ST_MAG-1].dx;
      pipe_in[ST_MAG].dmag[1] = pipe_ff[ST_MAG-1].dy[31] ? (~pipe_ff[ST_MAG-1].dy + 32'd1)
                                                         : pipe_ff[ST_MAG-1].dy;
      pipe_in[ST_MAG].dmag[2] = pipe_ff[ST_MAG-1].dz[31] ? (~pipe_ff[ST_MAG-1].dz + 32'd1)
                                                         : pipe_ff[ST_MAG-1].dz;
      for (int k = 0; k < 3; k++) begin
         pipe_in[ST_MAG].sq[k] = 64'(pipe_in[ST_MAG].dmag[k]) * 64'(pipe_in[ST_MAG].dmag[k]);
      end
      pipe_in[ST_MAG].qneg_i = pipe_ff[ST_MAG-1].qi[15];
      pipe_in[ST_MAG].qneg_j = pipe_ff[ST_MAG-1].qj[15];
      qm_i = pipe_ff[ST_MAG-1].qi[15] ? (~pipe_ff[ST_MAG-1].qi + 16'd1) : pipe_ff[ST_MAG-1].qi;
      qm_j = pipe_ff[ST_MAG-1].qj[15] ? (~pipe_ff[ST_MAG-1].qj + 16'd1) : pipe_ff[ST_MAG-1].qj;
      pipe_in[ST_MAG].q  = 31'(qm_i) * 31'(qm_j);
      pipe_in[ST_MAG].sk = 50'(pipe_ff[ST_MAG-1].scale) * 50'(k_coulomb_ff);

      // squared distance and skip test
      pipe_in[ST_R2].r2 = pipe_ff[ST_R2-1].sq[0] + pipe_ff[ST_R2-1].sq[1]
                          + pipe_ff[ST_R2-1].sq[2];
      pipe_in[ST_R2].skip = (pipe_in[ST_R2].r2 == 64'd0) || (pipe_ff[ST_R2-1].scale == 18'd0);

      // integer square root, a few bits per stage
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (j == 0) begin
            sx   = pipe_ff[ST_ROOT-1].r2;
            sres = 64'd0;
         end else begin
            sx   = pipe_ff[ST_ROOT+j-1].sx;
            sres = pipe_ff[ST_ROOT+j-1].sres;
         end
         for (int m = 0; m < SQRT_PER; m++) begin
            bitv = 64'd1 << (62 - 2 * (j * SQRT_PER + m));
            if (sx >= sres + bitv) begin
               sx   = sx - (sres + bitv);
               sres = (sres >> 1) + bitv;
            end else begin
               sres = sres >> 1;
            end
         end
         pipe_in[ST_ROOT+j].sx   = sx;
         pipe_in[ST_ROOT+j].sres = sres;
      end

      // skq and pair mass products from the multipliers
      pipe_in[ST_SKQ+1].skq = skq_prod[79:0];
      pipe_in[ST_PM+1].pm_i = pmi_prod[111:32];
      pipe_in[ST_PM+1].pm_j = pmj_prod[111:32];

      // alpha times r
      pipe_in[ST_U].u = 56'(alpha_ff) * 56'(pipe_ff[ST_U-1].sres[31:0]);

      // table position
      pw = (72'(pipe_ff[ST_P-1].u) * 72'(TABLE_ENTRIES)) / U_LIMIT;
      pipe_in[ST_P].inrange = pipe_ff[ST_P-1].u < (56'(U_LIMIT) << 32);
      pipe_in[ST_P].idx     = pw[32 +: IDX_W];
      pipe_in[ST_P].frac    = pw[31:0];

      // table read
      addr_a = pipe_ff[ST_ROM-1].inrange ? ROM_AW'(pipe_ff[ST_ROM-1].idx) : '0;
      addr_b = addr_a + ROM_AW'(1);
      pipe_in[ST_ROM].ea = EXP_ROM[addr_a];
      pipe_in[ST_ROM].eb = EXP_ROM[addr_b];
      pipe_in[ST_ROM].ca = ERFC_ROM[addr_a];
      pipe_in[ST_ROM].cb = ERFC_ROM[addr_b];

      // interpolation products
      pipe_in[ST_LERP].e_dn = pipe_ff[ST_LERP-1].ea >= pipe_ff[ST_LERP-1].eb;
      diff = pipe_in[ST_LERP].e_dn ? (pipe_ff[ST_LERP-1].ea - pipe_ff[ST_LERP-1].eb)
                                   : (pipe_ff[ST_LERP-1].eb - pipe_ff[ST_LERP-1].ea);
      pipe_in[ST_LERP].e_prod = 65'(diff) * 65'(pipe_ff[ST_LERP-1].frac);
      pipe_in[ST_LERP].c_dn = pipe_ff[ST_LERP-1].ca >= pipe_ff[ST_LERP-1].cb;
      diff = pipe_in[ST_LERP].c_dn ? (pipe_ff[ST_LERP-1].ca - pipe_ff[ST_LERP-1].cb)
                                   : (pipe_ff[ST_LERP-1].cb - pipe_ff[ST_LERP-1].ca);
      pipe_in[ST_LERP].c_prod = 65'(diff) * 65'(pipe_ff[ST_LERP-1].frac);

      // interpolated exp and erfc, zero past the table
      if (pipe_ff[ST_EC-1].inrange) begin
         pipe_in[ST_EC].e = pipe_ff[ST_EC-1].e_dn
                            ? 33'(pipe_ff[ST_EC-1].ea - pipe_ff[ST_EC-1].e_prod[64:32])
                            : 33'(pipe_ff[ST_EC-1].ea + pipe_ff[ST_EC-1].e_prod[64:32]);
         pipe_in[ST_EC].c = pipe_ff[ST_EC-1].c_dn
                            ? 33'(pipe_ff[ST_EC-1].ca - pipe_ff[ST_EC-1].c_prod[64:32])
                            : 33'(pipe_ff[ST_EC-1].ca + pipe_ff[ST_EC-1].c_prod[64:32]);
      end else begin
         pipe_in[ST_EC].e = 33'd0;
         pipe_in[ST_EC].c = 33'd0;
      end

      // gaussian term
      pipe_in[ST_TE].te = 66'(pipe_ff[ST_TE-1].e) * 66'(TWO_INV_SQRTPI);
      pipe_in[ST_T1].t1 = 42'((58'(pipe_ff[ST_T1-1].te[65:32]) * 58'(alpha_ff)) >> 16);

      // b = gaussian term + erfc(alpha r)/r
      pipe_in[ST_B].b = 50'(pipe_ff[ST_B-1].t1) + 50'(t2_quo[48:0]);

      // virial magnitude
      pipe_in[ST_BD+1].vmag = (vir_prod[191:64] > 128'(OUT_NEG_CAP)) ? OUT_NEG_CAP
                                                                     : vir_prod[111:64];
   end

   // output formatting
   always_comb begin
      pipe_type cur;
      logic     neg_i;
      cur = pipe_ff[LAST];
      rsp_in = '0;
      for (int k = 0; k < 3; k++) begin
         neg_i = (cur.qneg_i == cur.qneg_j) != cur.dneg[k];
         rsp_in.acc_i[k] = sat_out(acci_prod[k][191:64], neg_i);
         rsp_in.acc_j[k] = cur.ghost ? 48'd0 : sat_out(accj_prod[k][191:64], !neg_i);
      end
      rsp_in.vir = cur.count ? sat_out(128'(cur.vmag), cur.qneg_i != cur.qneg_j) : 48'd0;
      rsp_in.skipped = cur.skip;
      if (cur.skip) begin
         rsp_in = '0;
         rsp_in.skipped = 1'b1;
      end
   end

   // arithmetic units
   erspf_mul u_skq (
      .clock(clock), .advance(advance),
      .a(MUL_W'(pipe_ff[ST_MAG].sk)), .b(MUL_W'(pipe_ff[ST_MAG].q)), .prod(skq_prod)
   );
   erspf_mul u_pmi (
      .clock(clock), .advance(advance),
      .a(MUL_W'(skq_prod[79:0])), .b(MUL_W'(pipe_ff[ST_SKQ].mi)), .prod(pmi_prod)
   );
   erspf_mul u_pmj (
      .clock(clock), .advance(advance),
      .a(MUL_W'(skq_prod[79:0])), .b(MUL_W'(pipe_ff[ST_SKQ].mj)), .prod(pmj_prod)
   );
   erspf_div u_t2 (
      .clock(clock), .advance(advance),
      .num(DIV_NUM_W'(pipe_ff[ST_EC].c) << 16),
      .den(DIV_DEN_W'(pipe_ff[ST_EC].sres[31:0])),
      .quo(t2_quo)
   );
   erspf_mul u_vir (
      .clock(clock), .advance(advance),
      .a(MUL_W'(pipe_ff[ST_B].skq)), .b(MUL_W'(pipe_ff[ST_B].b)), .prod(vir_prod)
   );

   for (genvar k = 0; k < 3; k++) begin : g_axis
      erspf_mul u_bd (
         .clock(clock), .advance(advance),
         .a(MUL_W'(pipe_ff[ST_B].b)), .b(MUL_W'(pipe_ff[ST_B].dmag[k])), .prod(bd_prod[k])
      );
      erspf_div u_h (
         .clock(clock), .advance(advance),
         .num({bd_prod[k][80:0], 32'b0}),
         .den(pipe_ff[ST_BD].r2),
         .quo(h_quo[k])
      );
      erspf_mul u_acci (
         .clock(clock), .advance(advance),
         .a(MUL_W'(h_quo[k])), .b(MUL_W'(pipe_ff[ST_H].pm_i)), .prod(acci_prod[k])
      );
      erspf_mul u_accj (
         .clock(clock), .advance(advance),
         .a(MUL_W'(h_quo[k])), .b(MUL_W'(pipe_ff[ST_H].pm_j)), .prod(accj_prod[k])
      );
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
         rsp_ff  <= rsp_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[LAST-1:0], req_valid};
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   assign rsp_acc_first_x  = rsp_ff.acc_i[0];
   assign rsp_acc_first_y  = rsp_ff.acc_i[1];
   assign rsp_acc_first_z  = rsp_ff.acc_i[2];
   assign rsp_acc_second_x = rsp_ff.acc_j[0];
   assign rsp_acc_second_y = rsp_ff.acc_j[1];
   assign rsp_acc_second_z = rsp_ff.acc_j[2];
   assign rsp_virial_term  = rsp_ff.vir;
   assign rsp_skipped      = rsp_ff.skipped;

endmodule

@@ src/erspf_mul.sv @@
// pipelined 96x96 unsigned multiplier built from 32x32 partial products
module erspf_mul import erspf_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  logic [MUL_W-1:0]   a,
   input  logic [MUL_W-1:0]   b,
   output logic [2*MUL_W-1:0] prod
);

   logic [63:0]          pp_ff  [3][3];
   logic [63:0]          pp_in  [3][3];
   logic [127:0]         row_ff [3];
   logic [127:0]         row_in [3];
   logic [2*MUL_W-1:0]   prod_ff;
   logic [2*MUL_W-1:0]   prod_in;

   // partial products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pp_in[i][j] = a[32*i +: 32] * b[32*j +: 32];
         end
      end
   end

   // one row per limb of a
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         row_in[i] = 128'(pp_ff[i][0]) + (128'(pp_ff[i][1]) << 32)
                     + (128'(pp_ff[i][2]) << 64);
      end
   end

   // final sum
   assign prod_in = (2*MUL_W)'(row_ff[0]) + ((2*MUL_W)'(row_ff[1]) << 32)
                    + ((2*MUL_W)'(row_ff[2]) << 64);

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_ff   <= pp_in;
         row_ff  <= row_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

@@ src/erspf_div.sv @@
// pipelined restoring long divider, a few quotient bits per stage
module erspf_div import erspf_pkg::*; (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic [DIV_QUO_W-1:0] quo
);

   typedef struct packed {
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_QUO_W-1:0] low;
      logic [DIV_QUO_W-1:0] quo;
      logic [DIV_DEN_W-1:0] den;
   } div_stage_type;

   div_stage_type stage_ff [DIV_STAGES];
   div_stage_type stage_in [DIV_STAGES];

   // shift-subtract steps of every stage
   always_comb begin
      div_stage_type        cur;
      logic [DIV_DEN_W:0]   shifted;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            cur.rem = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_QUO_W]);
            cur.low = num[DIV_QUO_W-1:0];
            cur.quo = '0;
            cur.den = den;
         end else begin
            cur = stage_ff[s-1];
         end
         for (int m = 0; m < DIV_STEPS; m++) begin
            shifted = {cur.rem, cur.low[DIV_QUO_W-1]};
            cur.low = {cur.low[DIV_QUO_W-2:0], 1'b0};
            if (shifted >= {1'b0, cur.den}) begin
               cur.rem = DIV_DEN_W'(shifted - {1'b0, cur.den});
               cur.quo = {cur.quo[DIV_QUO_W-2:0], 1'b1};
            end else begin
               cur.rem = shifted[DIV_DEN_W-1:0];
               cur.quo = {cur.quo[DIV_QUO_W-2:0], 1'b0};
            end
         end
         stage_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign quo = stage_ff[DIV_STAGES-1].quo;

endmodule

@@ sim/ewald_real_space_pair_force_test.sv @@
// testbench for the ewald real-space pair force engine: directed table, random pairs, predictor
module ewald_real_space_pair_force_test import erspf_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM   = 930;
   localparam int LATENCY    = 65;
   localparam int CYCLE_CAP  = 400000;
   localparam logic [2:0] ADDR_ALPHA = 3'd0;
   localparam logic [2:0] ADDR_KCOUL = 3'd4;

   typedef struct {
      logic signed [31:0] dx, dy, dz;
      logic signed [15:0] qi, qj;
      logic [17:0]        scale;
      logic [31:0]        minv_i, minv_j;
      logic               virial_on, ghost;
   } pair_type;

   typedef struct packed {
      logic [47:0] ai_x, ai_y, ai_z, aj_x, aj_y, aj_z, vir;
      logic        skip;
   } force_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_dx = '0, req_dy = '0, req_dz = '0;
   logic signed [15:0] req_charge_first = '0, req_charge_second = '0;
   logic [17:0] req_pair_scale = '0;
   logic [31:0] req_mass_inv_first = '0, req_mass_inv_second = '0;
   logic req_count_virial = 1'b0, req_partner_ghost = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [47:0] rsp_acc_first_x, rsp_acc_first_y, rsp_acc_first_z;
   logic signed [47:0] rsp_acc_second_x, rsp_acc_second_y, rsp_acc_second_z;
   logic signed [47:0] rsp_virial_term;
   logic rsp_skipped;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   ewald_real_space_pair_force u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [63:0]  exp_tab [0:TABLE_ENTRIES];
   logic [63:0]  erfc_tab [0:TABLE_ENTRIES];
   logic [23:0]  alpha_q = 24'h010000;
   logic [31:0]  kcoul_q = 32'h00010000;

   force_type pending_forces[$];
   int     n_mismatch = 0;
   int     n_checked = 0;
   int     n_skipped_seen = 0;
   int     n_sat_seen = 0;
   longint cycles = 0;
   logic   long_hold = 1'b0;

   // exp(-v), q.32
   function automatic logic [63:0] neg_exp(input logic [63:0] v);
      logic [63:0] n, f, acc, term;
      n = v >> 32;
      f = {32'b0, v[31:0]};
      acc = 64'h1_0000_0000;
      term = 64'h1_0000_0000;
      if (n >= 23) return 64'd0;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * f) >> 32) / 64'(k);
         if (k % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      for (longint k = 0; k < n; k++) acc = (acc * 64'd1580030169) >> 32;
      return acc;
   endfunction

   function automatic logic [63:0] half_grid_exp(input logic [63:0] j);
      logic [63:0] u24;
      u24 = (j * (64'd8 << 23)) / 64'(TABLE_ENTRIES);
      return neg_exp((u24 * u24) >> 16);
   endfunction

   task automatic build_tables();
      logic [63:0]  s, v;
      logic [127:0] p;
      s = 0;
      for (int i = 0; i <= TABLE_ENTRIES; i++) exp_tab[i] = half_grid_exp(64'(2 * i));
      erfc_tab[TABLE_ENTRIES] = 0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         s = s + half_grid_exp(64'(2 * i)) + 4 * half_grid_exp(64'(2 * i + 1))
             + half_grid_exp(64'(2 * i + 2));
         p = 128'(s) * 128'(64'd6461802160);
         v = p[95:32] / 64'(TABLE_ENTRIES);
         erfc_tab[i] = (v > 64'h1_0000_0000) ? 64'h1_0000_0000 : v;
      end
   endtask

   localparam logic [127:0] ALL_ONES = {128{1'b1}};

   // 128 bit product, saturating
   function automatic logic [127:0] mul_clamp(input logic [127:0] a, input logic [127:0] b);
      logic [255:0] p;
      p = 256'(a) * 256'(b);
      return (p[255:128] != 0) ? ALL_ONES : p[127:0];
   endfunction

   function automatic logic [127:0] interp(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] fr);
      logic [127:0] d;
      if (a >= b) begin
         d = (128'(a - b) * 128'(fr)) >> 32;
         return 128'(a - d[63:0]);
      end
      d = (128'(b - a) * 128'(fr)) >> 32;
      return 128'(a + d[63:0]);
   endfunction

   function automatic logic [47:0] clamp_signed(input logic [127:0] m, input logic neg);
      logic [63:0] cap, v;
      cap = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      v = (m[127:64] != 0 || m[63:0] > cap) ? cap : m[63:0];
      return neg ? 48'(64'd0 - v) : v[47:0];
   endfunction

   function automatic logic [63:0] isqrt(input logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else res = res >> 1;
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] abs_val(input logic [63:0] v, input int w, output logic neg);
      logic [63:0] m;
      m = (64'd1 << w) - 1;
      v = v & m;
      neg = v[w-1];
      return neg ? ((m - v) + 1) : v;
   endfunction

   function automatic force_type pair_force(input pair_type p);
      force_type f;
      logic [63:0]  dm [3];
      logic         dn [3];
      logic         ni, nj, neg_i;
      logic [63:0]  r2, r, u, e, c, t1, t2, b, q, sk, idx, fr;
      logic [127:0] pu, tmp, skq, pm_i, pm_j, h;
      logic [47:0]  cl;
      f = '{default: '0};
      r2 = 0;
      dm[0] = abs_val(64'(unsigned'(p.dx)), 32, dn[0]);
      dm[1] = abs_val(64'(unsigned'(p.dy)), 32, dn[1]);
      dm[2] = abs_val(64'(unsigned'(p.dz)), 32, dn[2]);
      for (int k = 0; k < 3; k++) r2 = r2 + dm[k] * dm[k];
      if (r2 == 0 || p.scale == 0) begin
         f.skip = 1'b1;
         return f;
      end
      r = isqrt(r2);
      u = 64'(alpha_q) * r;
      e = 0;
      c = 0;
      if (u < (64'd8 << 32)) begin
         pu = (128'(u) * TABLE_ENTRIES) / 8;
         idx = pu[95:32];
         fr = {32'b0, pu[31:0]};
         if (idx < TABLE_ENTRIES) begin
            tmp = interp(exp_tab[idx], exp_tab[idx + 1], fr);
            e = tmp[63:0];
            tmp = interp(erfc_tab[idx], erfc_tab[idx + 1], fr);
            c = tmp[63:0];
         end
      end
      tmp = (128'(64'd4846351620) * 128'(e)) >> 32;
      t1 = (tmp[63:0] * 64'(alpha_q)) >> 16;
      tmp = (128'(c) << 16) / 128'(r);
      t2 = tmp[63:0];
      b = t1 + t2;
      q = abs_val(64'(unsigned'(p.qi)), 16, ni) * abs_val(64'(unsigned'(p.qj)), 16, nj);
      sk = 64'(p.scale) * 64'(kcoul_q);
      skq = 128'(sk) * 128'(q);
      pm_i = mul_clamp(skq, 128'(p.minv_i)) >> 32;
      pm_j = mul_clamp(skq, 128'(p.minv_j)) >> 32;
      for (int k = 0; k < 3; k++) begin
         tmp = 128'(b) * 128'(dm[k]);
         h = (tmp << 32) / 128'(r2);
         neg_i = (ni == nj) != dn[k];
         cl = clamp_signed(mul_clamp(h, pm_i) >> 64, neg_i);
         case (k)
            0: f.ai_x = cl;
            1: f.ai_y = cl;
            default: f.ai_z = cl;
         endcase
         if (!p.ghost) begin
            cl = clamp_signed(mul_clamp(h, pm_j) >> 64, !neg_i);
            case (k)
               0: f.aj_x = cl;
               1: f.aj_y = cl;
               default: f.aj_z = cl;
            endcase
         end
      end
      if (p.virial_on) f.vir = clamp_signed(mul_clamp(skq, 128'(b)) >> 64, ni != nj);
      return f;
   endfunction

   // cycle count and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_forces.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver stall pattern, with long holds when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold) begin
         rsp_stall <= 1'b1;
      end else if (cycles % 2000 < 600) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   task automatic report(input string what, input logic [47:0] want, input logic [47:0] got);
      n_mismatch++;
      if (n_mismatch <= 10)
         $display("mismatch %s: expected %h actual %h", what, want, got);
   endtask

   // result checker
   always @(posedge clock) begin
      force_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_forces.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("mismatch: result with no request outstanding");
         end else begin
            w = pending_forces.pop_front();
            n_checked++;
            if (rsp_skipped) n_skipped_seen++;
            if (rsp_acc_first_x == OUT_POS_CAP || rsp_acc_first_x == OUT_NEG_CAP)
               n_sat_seen++;
            if (rsp_acc_first_x !== w.ai_x) report("acc_first_x", w.ai_x, rsp_acc_first_x);
            if (rsp_acc_first_y !== w.ai_y) report("acc_first_y", w.ai_y, rsp_acc_first_y);
            if (rsp_acc_first_z !== w.ai_z) report("acc_first_z", w.ai_z, rsp_acc_first_z);
            if (rsp_acc_second_x !== w.aj_x) report("acc_second_x", w.aj_x, rsp_acc_second_x);
            if (rsp_acc_second_y !== w.aj_y) report("acc_second_y", w.aj_y, rsp_acc_second_y);
            if (rsp_acc_second_z !== w.aj_z) report("acc_second_z", w.aj_z, rsp_acc_second_z);
            if (rsp_virial_term !== w.vir) report("virial_term", w.vir, rsp_virial_term);
            if (rsp_skipped !== w.skip) report("skipped", 48'(w.skip), 48'(rsp_skipped));
         end
      end
   end

   // drive one request, hold until accepted
   task automatic send_pair(input pair_type p, input logic has_want, input force_type want);
      force_type f;
      req_valid <= 1'b1;
      req_dx <= p.dx;
      req_dy <= p.dy;
      req_dz <= p.dz;
      req_charge_first <= p.qi;
      req_charge_second <= p.qj;
      req_pair_scale <= p.scale;
      req_mass_inv_first <= p.minv_i;
      req_mass_inv_second <= p.minv_j;
      req_count_virial <= p.virial_on;
      req_partner_ghost <= p.ghost;
      f = pair_force(p);
      if (has_want && f !== want) begin
         n_mismatch++;
         if (n_mismatch <= 10) $display("mismatch: predictor disagrees with table row");
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_forces.push_back(has_want ? want : f);
   endtask

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_ALPHA) alpha_q = data[23:0];
      else kcoul_q = data;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_disp();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
         2: return 32'(signed'($urandom_range(0, 1 << 17)) - (1 << 16));
         3: return 32'(signed'($urandom_range(0, 64)) - 32);
         default: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
      endcase
   endfunction

   function automatic pair_type rand_pair();
      pair_type p;
      p.dx = rand_disp();
      p.dy = ($urandom_range(0, 9) == 0) ? 32'sd0 : rand_disp();
      p.dz = rand_disp();
      p.qi = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(signed'($urandom_range(0, 1024)) - 512);
      p.qj = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(signed'($urandom_range(0, 1024)) - 512);
      p.scale = ($urandom_range(0, 19) == 0) ? 18'd0 : 18'($urandom);
      p.minv_i = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1 << 18);
      p.minv_j = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1 << 18);
      p.virial_on = $urandom_range(0, 1);
      p.ghost = $urandom_range(0, 1);
      if ($urandom_range(0, 49) == 0) begin
         p.dx = 0;
         p.dy = 0;
         p.dz = 0;
      end
      return p;
   endfunction

   // directed table: pair, whether the result is typed in, result
   pair_type  dir_pairs [20];
   logic      dir_fixed [20];
   force_type dir_want  [20];
   force_type skip_res, zero_res;

   task automatic fill_table();
      pair_type base;
      base = '{dx: 32'sh0001_0000, dy: 32'sh0, dz: 32'sh0, qi: 16'sh0100, qj: 16'sh0100,
               scale: 18'h10000, minv_i: 32'h0001_0000, minv_j: 32'h0001_0000,
               virial_on: 1'b1, ghost: 1'b0};
      for (int i = 0; i < 20; i++) begin
         dir_pairs[i] = base;
         dir_fixed[i] = 1'b0;
      end
      // zero displacement
      dir_pairs[0].dx = 0;
      dir_fixed[0] = 1'b1;
      dir_want[0] = skip_res;
      // zero scale
      dir_pairs[1].scale = 0;
      dir_fixed[1] = 1'b1;
      dir_want[1] = skip_res;
      // zero charge gives all zeros
      dir_pairs[2].qi = 0;
      dir_fixed[2] = 1'b1;
      dir_want[2] = zero_res;
      // zero masses, no virial
      dir_pairs[3].minv_i = 0;
      dir_pairs[3].minv_j = 0;
      dir_pairs[3].virial_on = 0;
      dir_fixed[3] = 1'b1;
      dir_want[3] = zero_res;
      // unit pair, then ghost and virial variants
      dir_pairs[5].ghost = 1'b1;
      dir_pairs[6].virial_on = 1'b0;
      // extremes of displacement
      dir_pairs[7] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh8000,
                       18'h3FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0};
      dir_pairs[8] = '{32'sh1, 32'sh0, 32'sh0, 16'sh7FFF, 16'sh7FFF,
                       18'h3FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0};
      dir_pairs[9] = '{32'shFFFF_FFFF, 32'sh1, 32'shFFFF_FFFF, 16'sh8000, 16'sh8000,
                       18'h1, 32'h1, 32'h1, 1'b1, 1'b1};
      // opposite charges, negative directions
      dir_pairs[10].qj = 16'shFF00;
      dir_pairs[10].dy = 32'shFFFF_0000;
      dir_pairs[11].dz = 32'sh0003_8000;
      dir_pairs[11].dx = -32'sh0000_4000;
      // beyond and just inside the end of the table: large r
      dir_pairs[12].dx = 32'sh0010_0000;
      dir_pairs[13].dx = 32'sh0007_FF00;
      dir_pairs[14] = '{32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F, 16'sh5A5A, 16'shA5A5,
                        18'h2AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1};
      dir_pairs[15] = '{32'shEDCB_A987, 32'sh1234_5678, 32'shF0F0_F0F0, 16'shA5A5, 16'sh5A5A,
                        18'h15555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0};
      for (int i = 16; i < 20; i++) dir_pairs[i].dx = 32'sh0000_8000 << (i - 16);
   endtask

   initial begin
      int total, burst, alpha_cfg [4], k_cfg [4];
      pair_type p;
      skip_res = '{default: '0};
      skip_res.skip = 1'b1;
      zero_res = '{default: '0};
      alpha_cfg = '{32'h0000_0000, 32'h00FF_FFFF, 32'h0000_4000, 32'h0002_8000};
      k_cfg = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0138_0000};
      build_tables();
      fill_table();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset configuration
      foreach (dir_pairs[i]) send_pair(dir_pairs[i], dir_fixed[i], dir_want[i]);
      drain();
      // zero alpha, extreme k
      csr_write(ADDR_ALPHA, 32'h0);
      csr_write(ADDR_KCOUL, 32'hFFFF_FFFF);
      for (int i = 4; i < 10; i++) send_pair(dir_pairs[i], 1'b0, zero_res);
      drain();

      // random phases across settings
      total = 0;
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(ADDR_ALPHA, alpha_cfg[ph]);
         csr_write(ADDR_KCOUL, k_cfg[ph]);
         if (ph == 2) begin
            fork
               begin
                  long_hold = 1'b1;
                  repeat (300) @(posedge clock);
                  long_hold = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < N_RANDOM / 4; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM / 4; b++, n++) begin
               p = rand_pair();
               send_pair(p, 1'b0, zero_res);
               total++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
         end
         drain();
      end
      csr_write(ADDR_ALPHA, 32'h0001_0000);
      csr_write(ADDR_KCOUL, 32'h0001_0000);
      drain();

      $display("covered %0d random pairs plus directed rows over 5 settings", total);
      $display("checked %0d results, %0d skipped, %0d clamped", n_checked, n_skipped_seen,
               n_sat_seen);
      if (n_mismatch == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", n_mismatch);
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

@@ sim.f @@
src/erspf_pkg.sv
src/erspf_mul.sv
src/erspf_div.sv
src/ewald_real_space_pair_force.sv
sim/ewald_real_space_pair_force_test.sv
